FILE: design/sitda_pkg.sv
package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // add 3 to every bcd digit of 5 or more, ahead of the left shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

    // every digit holds a legal decimal value
    function automatic logic bcd_legal(input logic [BCD_W-1:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[4*i +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

FILE: design/signed_int_to_decimal_ascii_unit.sv
// after the input transfer the sequencer makes 32 shift-add-3 passes through the
// shared bcd adjust unit, skips leading zeros (0 to 9 of them), then puts out the sign,
// if any, and the digits, one character per cycle while the output side keeps up;
// a new value is taken only once the sequencer is back in idle, after the last
// character of the previous value has entered the output register
// reset: rst_n is asynchronous and active low; it returns the sequencer to idle
// and drops the output valid, no result is left pending
module signed_int_to_decimal_ascii_unit
    import sitda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               value_valid,
    output logic               value_ready,
    input  logic signed [31:0] value,

    output logic               char_valid,
    input  logic               char_ready,
    output logic        [7:0]  character,
    output logic               last_char
);

    // sequencer and datapath registers
    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                   neg_reg, neg_next;

    // output register, parts the sequencer from the consumer
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;

    logic                   slot_free;
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;
    logic [VALUE_W-1:0]     in_raw;

    assign value_ready = (state_reg == ST_IDLE);
    assign char_valid  = out_valid_reg;
    assign character   = out_char_reg;
    assign last_char   = out_last_reg;

    // output slot can take a character this cycle
    assign slot_free = !out_valid_reg || char_ready;

    // shared adjust unit, used once per conversion pass
    assign bcd_adj   = bcd_adjust(bcd_reg);
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign in_raw    = value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        // the consumer took the pending character
        out_valid_next = out_valid_reg && !char_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    // take the unsigned magnitude; the most negative value maps to 2^31
                    neg_next     = in_raw[VALUE_W-1];
                    mag_next     = in_raw[VALUE_W-1] ? (~in_raw + 1'b1) : in_raw;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONVERT;
                end
            end

            ST_CONVERT:
            begin
                // one double-dabble pass: adjust, then shift one magnitude bit in
                {bcd_next, mag_next} = {bcd_adj[BCD_W-2:0], mag_reg, 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    state_next   = ST_SKIP;
                end
            end

            ST_SKIP:
            begin
                // drop leading zeros, always keep the ones digit
                if (top_digit == 4'd0 && dig_cnt_reg > DIG_CNT_W'(1))
                begin
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end

            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ASCII_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ASCII_ZERO | {4'd0, top_digit};
                    out_last_next  = (dig_cnt_reg == DIG_CNT_W'(1));
                    bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next   = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DIG_CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // digit count never exceeds the number of bcd digits
    a_dig_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        dig_cnt_reg <= DIG_CNT_W'(NUM_DIGITS))
        else $error("digit count out of range");

    // the bcd register stays legal while the conversion runs
    a_bcd_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONVERT) |-> bcd_legal(bcd_reg))
        else $error("illegal bcd digit during conversion");

    // emitting always has a digit left
    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (dig_cnt_reg != '0))
        else $error("emit with no digits left");

    // the final digit transfer into the slot is flagged last and frees the block
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_free && dig_cnt_reg == DIG_CNT_W'(1))
        |=> (state_reg == ST_IDLE && out_valid_reg && out_last_reg))
        else $error("last character did not end the run");

    // an accepted value starts a conversion
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (value_valid && value_ready) |=> (state_reg == ST_CONVERT))
        else $error("accepted value did not start conversion");

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    import sitda_pkg::*;

    // cycle budget: about 400 numbers, each a full conversion plus up to eleven
    // characters behind a receiver that stalls often, taken many times over
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 380;
    // drain time after the last character, longer than the conversion of one number
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_LIMIT = 10;

    // one character of expected text
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic               clk;
    logic               rst_n;
    logic               value_valid;
    logic               value_ready;
    logic signed [31:0] value;
    logic               char_valid;
    logic               char_ready;
    logic        [7:0]  character;
    logic               last_char;

    // numbers still to be sent, and the characters they must turn into
    logic signed [31:0] value_backlog[$];
    text_char_t         pending_text[$];

    int stim_total;
    int items_sent;
    int idle_phase;
    int mismatch_count;
    int cycle_count;

    signed_int_to_decimal_ascii_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value       (value),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .character   (character),
        .last_char   (last_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // decimal text of one number: optional minus sign, then digits most
    // significant first, no leading zeros; the magnitude is taken unsigned so
    // the most negative value comes out as 2147483648
    function automatic void expand_decimal_text(input logic signed [31:0] v);
        logic [31:0] mag;
        logic [7:0]  digit_chars[10];
        int          ndig;
        text_char_t  tc;
        ndig = 0;
        mag  = v[31] ? (32'd0 - v) : v;
        do
        begin
            digit_chars[ndig] = ASCII_ZERO + 8'(mag % 32'd10);
            mag = mag / 32'd10;
            ndig++;
        end
        while (mag != 32'd0);
        if (v[31])
        begin
            tc.ch   = ASCII_MINUS;
            tc.last = 1'b0;
            pending_text.push_back(tc);
        end
        for (int k = ndig - 1; k >= 0; k--)
        begin
            tc.ch   = digit_chars[k];
            tc.last = (k == 0);
            pending_text.push_back(tc);
        end
    endfunction

    function automatic void note_mismatch(input string what, input int exp_val,
                                          input int act_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("mismatch %0d: %s expected 0x%0h got 0x%0h",
                     mismatch_count, what, exp_val, act_val);
        end
    endfunction

    // magnitude with a chosen number of decimal digits, then a random sign
    function automatic logic signed [31:0] pick_sized_value(input int ndig);
        longint lo;
        longint hi;
        logic [31:0] mag;
        lo = 1;
        for (int i = 1; i < ndig; i++)
        begin
            lo = lo * 10;
        end
        hi = lo * 10 - 1;
        if (ndig == 1)
        begin
            lo = 0;
        end
        if (hi > 64'd2147483647)
        begin
            hi = 64'd2147483647;
        end
        mag = $urandom_range(32'(hi), 32'(lo));
        return ($urandom_range(1) == 1) ? -$signed(mag) : $signed(mag);
    endfunction

    // powers of ten and their neighbors, where the digit count changes
    function automatic logic signed [31:0] pick_boundary_value();
        longint p;
        logic [31:0] mag;
        int sel;
        p = 1;
        sel = $urandom_range(9);
        for (int i = 0; i < sel; i++)
        begin
            p = p * 10;
        end
        case ($urandom_range(2))
            0: mag = 32'(p - 1);
            1: mag = 32'(p);
            default: mag = 32'(p + 1);
        endcase
        return ($urandom_range(1) == 1) ? -$signed(mag) : $signed(mag);
    endfunction

    // idle rates per phase: sender light and receiver heavy, then swapped,
    // then both sides at full rate
    function automatic int sender_idle_pct(input int ph);
        return (ph == 0) ? 27 : (ph == 1) ? 64 : 0;
    endfunction

    function automatic int receiver_idle_pct(input int ph);
        return (ph == 0) ? 64 : (ph == 1) ? 27 : 0;
    endfunction

    // sender: a transfer on the input side is predicted on the edge where it
    // happens; a waiting number is held unchanged until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        logic               next_valid;
        logic signed [31:0] next_value;
        if (!rst_n)
        begin
            value_valid <= 1'b0;
            value       <= '0;
            items_sent  <= 0;
            idle_phase  <= 0;
        end
        else
        begin
            next_valid = value_valid;
            next_value = value;
            if (value_valid && value_ready)
            begin
                expand_decimal_text(value);
                next_valid = 1'b0;
            end
            if (!next_valid && value_backlog.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(idle_phase))
            begin
                next_valid = 1'b1;
                next_value = value_backlog.pop_front();
                items_sent <= items_sent + 1;
                idle_phase <= ((items_sent + 1) * 3) / stim_total;
            end
            value_valid <= next_valid;
            value       <= next_value;
        end
    end

    // receiver: each character transfer is checked against the oldest
    // expected character, then ready is redrawn for the next cycle
    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            char_ready <= 1'b0;
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                if (pending_text.size() == 0)
                begin
                    note_mismatch("unexpected character", 0, int'(character));
                end
                else
                begin
                    want = pending_text.pop_front();
                    if (character !== want.ch)
                    begin
                        note_mismatch("character", int'(want.ch), int'(character));
                    end
                    if (last_char !== want.last)
                    begin
                        note_mismatch("last_char", int'(want.last), int'(last_char));
                    end
                end
            end
            char_ready <= ($urandom_range(99) >= receiver_idle_pct(idle_phase));
        end
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        rst_n          = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;

        // directed numbers: zero, single digits, texts of one, two, three, five,
        // six, nine and ten digits, both extremes of the field, the most negative
        // value through its unsigned magnitude, and alternating bit patterns
        value_backlog.push_back(32'sd0);
        value_backlog.push_back(32'sd1);
        value_backlog.push_back(-32'sd1);
        value_backlog.push_back(32'sd9);
        value_backlog.push_back(32'sd10);
        value_backlog.push_back(-32'sd10);
        value_backlog.push_back(32'sd99);
        value_backlog.push_back(-32'sd100);
        value_backlog.push_back(32'sd12345);
        value_backlog.push_back(-32'sd908070);
        value_backlog.push_back(32'sd999999999);
        value_backlog.push_back(32'sd1000000000);
        value_backlog.push_back(-32'sd1000000000);
        value_backlog.push_back(32'sd1999999999);
        value_backlog.push_back(32'sd2147483647);
        value_backlog.push_back(32'sd2147483646);
        value_backlog.push_back(-32'sd2147483647);
        value_backlog.push_back(32'h8000_0000);
        value_backlog.push_back(32'h5555_5555);
        value_backlog.push_back(32'hAAAA_AAAA);
        value_backlog.push_back(32'h0000_FFFF);
        value_backlog.push_back(32'hFFFF_0000);
        value_backlog.push_back(32'sd7);

        // random part: full-width patterns for bit coverage, numbers of a
        // chosen digit count so short and long texts both appear, and
        // values right at the digit-count boundaries
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                value_backlog.push_back($signed($urandom()));
            end
            else if (r < 85)
            begin
                value_backlog.push_back(pick_sized_value($urandom_range(10, 1)));
            end
            else
            begin
                value_backlog.push_back(pick_boundary_value());
            end
        end
        stim_total = value_backlog.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // all numbers handed over, then all text back, then a quiet tail
        // so a stray extra character would still be caught
        while (value_backlog.size() != 0 || value_valid)
        begin
            @(posedge clk);
        end
        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_text.size() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
